/* design/hpp_pkg.sv */
// ----------------------------------------------------------------------------
// hpp_pkg: shared types and constants of the two-polynomial Horner core
// Field widths, polynomial layout and the sequencer encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package hpp_pkg;

  localparam int unsigned X_WIDTH     = 36;
  localparam int unsigned P1_WIDTH    = 64;
  localparam int unsigned P2_WIDTH    = 45;
  localparam int unsigned PROD_WIDTH  = 63;
  localparam int unsigned PROD_FRAC   = 12;
  localparam int unsigned X_LIMIT_INT = 5;

  // Coefficient table layout: p1 uses entries 0..10, p2 uses 11..17.
  localparam logic [4:0] P1_FIRST_IDX = 5'd10;
  localparam logic [4:0] P1_LAST_IDX  = 5'd0;
  localparam logic [4:0] P2_FIRST_IDX = 5'd17;
  localparam logic [4:0] P2_LAST_IDX  = 5'd11;

  // Number of 32x32 partial products per multiplication.
  localparam logic [2:0] HORNER_PARTS = 3'd2;
  localparam logic [2:0] PROD_PARTS   = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MUL,
    ST_FIN,
    ST_RESULT
  } state_e;

  typedef enum logic [1:0] {
    PH_P1,
    PH_P2,
    PH_PROD
  } phase_e;

endpackage

`default_nettype wire

/* design/hpp_in_if.sv */
// ----------------------------------------------------------------------------
// hpp_in_if: argument channel
// Valid/ready channel that carries one fixed-point argument per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpp_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [hpp_pkg::X_WIDTH-1:0] x_value;

  modport source (output valid, output x_value, input ready);
  modport sink   (input valid, input x_value, output ready);
endinterface

`default_nettype wire

/* design/hpp_out_if.sv */
// ----------------------------------------------------------------------------
// hpp_out_if: result channel
// Valid/ready channel that carries p1, p2, their product and a range flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface hpp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  range_error;
  logic signed [hpp_pkg::P1_WIDTH-1:0]   first_poly;
  logic signed [hpp_pkg::P2_WIDTH-1:0]   second_poly;
  logic signed [hpp_pkg::PROD_WIDTH-1:0] poly_product;

  modport source (output valid, output range_error, output first_poly,
                  output second_poly, output poly_product, input ready);
  modport sink   (input valid, input range_error, input first_poly,
                  input second_poly, input poly_product, output ready);
endinterface

`default_nettype wire

/* design/horner_two_poly_product_core.sv */
// ----------------------------------------------------------------------------
// horner_two_poly_product_core: fixed-point Horner evaluator of p1, p2, p1*p2
// Each argument is carried through to a registered result before the next one
// is accepted: an in-range argument runs 18 Horner steps and the final product
// through the single shared 32x32 multiplier that every step passes through;
// an out-of-range argument goes straight to the result register, which is
// loaded only once the previous result has been taken or none is pending.
// Reset (rst_ni low, asynchronous): sequencer idle, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module horner_two_poly_product_core #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  hpp_in_if.sink        in_i,
  hpp_out_if.source     out_o
);

  // Every multiplication is done as magnitude times magnitude by a single
  // 32x32 unsigned multiplier. The partial products are summed into a
  // 128-bit register that is preloaded with the rounding half, so the
  // finish cycle only shifts, clamps, restores the sign and adds the next
  // coefficient with saturation.
  //
  // Horner step: SETUP (magnitudes and sign), MUL (two partial products, then
  // the last registered product is folded into the sum), FIN (round, add).
  // Final product: the same sequence with four partial products.

  localparam int unsigned SH_HORNER = FRAC_BITS;
  localparam int unsigned SH_PROD   = 2 * FRAC_BITS - hpp_pkg::PROD_FRAC;

  localparam logic [127:0] HALF_HORNER = 128'd1 << (SH_HORNER - 1);
  localparam logic [127:0] HALF_PROD   = 128'd1 << (SH_PROD - 1);

  localparam logic [63:0] MAXPOS_HORNER = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MAXPOS_PROD   = 64'h3FFF_FFFF_FFFF_FFFF;

  // Inputs outside [-5, 5] in fixed point are flagged as range errors.
  localparam logic signed [hpp_pkg::X_WIDTH-1:0] X_LIMIT =
    hpp_pkg::X_WIDTH'(hpp_pkg::X_LIMIT_INT) <<< FRAC_BITS;

  // Coefficients, rounded to nearest with FRAC_BITS fraction bits.
  localparam logic signed [63:0] COEF_X6_P1  = ((64'sd6243 <<< FRAC_BITS) + 64'sd5) / 64'sd10;
  localparam logic signed [63:0] COEF_X8_P1  =
    -(((64'sd5253243 <<< FRAC_BITS) + 64'sd50) / 64'sd100);
  localparam logic signed [63:0] COEF_X10_P1 =
    -(((64'sd12107 <<< FRAC_BITS) + 64'sd2500) / 64'sd5000);
  localparam logic signed [63:0] COEF_ONE    = 64'sd1 <<< FRAC_BITS;

  localparam logic signed [hpp_pkg::P2_WIDTH-1:0] P2_MAX =
    {1'b0, {(hpp_pkg::P2_WIDTH-1){1'b1}}};
  localparam logic signed [hpp_pkg::P2_WIDTH-1:0] P2_MIN =
    {1'b1, {(hpp_pkg::P2_WIDTH-1){1'b0}}};

  // Sequencer state.
  hpp_pkg::state_e state_q, state_d;
  hpp_pkg::phase_e phase_q, phase_d;
  logic [4:0]      coef_idx_q, coef_idx_d;
  logic [2:0]      part_cnt_q, part_cnt_d;
  logic [2:0]      part_num_q, part_num_d;
  logic            out_valid_q, out_valid_d;

  // Datapath registers.
  logic signed [hpp_pkg::X_WIDTH-1:0]    x_q, x_d;
  logic                                  err_q, err_d;
  logic signed [63:0]                    acc_q, acc_d;
  logic signed [63:0]                    p1_q, p1_d;
  logic signed [hpp_pkg::P2_WIDTH-1:0]   p2_q, p2_d;
  logic signed [hpp_pkg::PROD_WIDTH-1:0] prod_q, prod_d;
  logic [63:0]                           a_mag_q, a_mag_d;
  logic [63:0]                           b_mag_q, b_mag_d;
  logic                                  neg_q, neg_d;
  logic [127:0]                          sum_q, sum_d;
  logic [63:0]                           pp_q, pp_d;
  logic [1:0]                            pp_shift_q, pp_shift_d;

  logic                                  out_err_q, out_err_d;
  logic signed [hpp_pkg::P1_WIDTH-1:0]   out_p1_q, out_p1_d;
  logic signed [hpp_pkg::P2_WIDTH-1:0]   out_p2_q, out_p2_d;
  logic signed [hpp_pkg::PROD_WIDTH-1:0] out_prod_q, out_prod_d;

  // Combinational helpers.
  logic               in_fire;
  logic               out_free;
  logic signed [63:0] coef;
  logic signed [63:0] op_a, op_b;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [127:0]       shifted;
  logic [63:0]        rlo, limit, maxpos;
  logic               rhi_nz;
  logic signed [65:0] fin_sum;
  logic signed [63:0] fin_val;
  logic signed [hpp_pkg::P2_WIDTH-1:0] p2_sat;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  assign in_i.ready         = (state_q == hpp_pkg::ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.range_error  = out_err_q;
  assign out_o.first_poly   = out_p1_q;
  assign out_o.second_poly  = out_p2_q;
  assign out_o.poly_product = out_prod_q;

  // Constant coefficient table; the product phase adds nothing.
  always_comb begin
    case (coef_idx_q)
      5'd6:    coef = COEF_X6_P1;
      5'd8:    coef = COEF_X8_P1;
      5'd10:   coef = COEF_X10_P1;
      5'd14:   coef = -COEF_ONE;
      5'd15:   coef = COEF_ONE <<< 1;
      5'd16:   coef = -COEF_ONE;
      5'd17:   coef = COEF_ONE;
      default: coef = 64'sd0;
    endcase
    if (phase_q == hpp_pkg::PH_PROD) begin
      coef = 64'sd0;
    end
  end

  // Operand selection for the setup cycle.
  assign op_a = (phase_q == hpp_pkg::PH_PROD) ? p1_q : acc_q;
  assign op_b = (phase_q == hpp_pkg::PH_PROD) ? 64'(p2_q) : 64'(x_q);

  // Shared multiplier. Partial index bit 0 picks the half of a, bit 1 of b.
  assign mul_a = part_cnt_q[0] ? a_mag_q[63:32] : a_mag_q[31:0];
  assign mul_b = part_cnt_q[1] ? b_mag_q[63:32] : b_mag_q[31:0];
  assign mul_p = mul_a * mul_b;

  // Finish: scale down, clamp the magnitude, restore sign, add coefficient.
  always_comb begin
    if (phase_q == hpp_pkg::PH_PROD) begin
      shifted = sum_q >> SH_PROD;
      maxpos  = MAXPOS_PROD;
    end else begin
      shifted = sum_q >> SH_HORNER;
      maxpos  = MAXPOS_HORNER;
    end
    rhi_nz = |shifted[127:64];
    limit  = neg_q ? (maxpos + 64'd1) : maxpos;
    rlo    = (rhi_nz || (shifted[63:0] > limit)) ? limit : shifted[63:0];
    fin_sum = neg_q ? (66'(coef) - $signed({2'b00, rlo}))
                    : (66'(coef) + $signed({2'b00, rlo}));
    if (fin_sum > 66'sh0_7FFF_FFFF_FFFF_FFFF) begin
      fin_val = 64'sh7FFF_FFFF_FFFF_FFFF;
    end else if (fin_sum < -66'sh0_8000_0000_0000_0000) begin
      fin_val = 64'sh8000_0000_0000_0000;
    end else begin
      fin_val = fin_sum[63:0];
    end
    if (fin_val > 64'(P2_MAX)) begin
      p2_sat = P2_MAX;
    end else if (fin_val < 64'(P2_MIN)) begin
      p2_sat = P2_MIN;
    end else begin
      p2_sat = fin_val[hpp_pkg::P2_WIDTH-1:0];
    end
  end

  // Next state and datapath updates.
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    coef_idx_d  = coef_idx_q;
    part_cnt_d  = part_cnt_q;
    part_num_d  = part_num_q;
    out_valid_d = out_valid_q;
    x_d         = x_q;
    err_d       = err_q;
    acc_d       = acc_q;
    p1_d        = p1_q;
    p2_d        = p2_q;
    prod_d      = prod_q;
    a_mag_d     = a_mag_q;
    b_mag_d     = b_mag_q;
    neg_d       = neg_q;
    sum_d       = sum_q;
    pp_d        = pp_q;
    pp_shift_d  = pp_shift_q;
    out_err_d   = out_err_q;
    out_p1_d    = out_p1_q;
    out_p2_d    = out_p2_q;
    out_prod_d  = out_prod_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      hpp_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_d = in_i.x_value;
          if ((in_i.x_value < -X_LIMIT) || (in_i.x_value > X_LIMIT)) begin
            err_d   = 1'b1;
            state_d = hpp_pkg::ST_RESULT;
          end else begin
            err_d      = 1'b0;
            acc_d      = 64'sd0;
            phase_d    = hpp_pkg::PH_P1;
            coef_idx_d = hpp_pkg::P1_FIRST_IDX;
            state_d    = hpp_pkg::ST_SETUP;
          end
        end
      end

      hpp_pkg::ST_SETUP: begin
        a_mag_d    = op_a[63] ? (64'd0 - 64'(op_a)) : 64'(op_a);
        b_mag_d    = op_b[63] ? (64'd0 - 64'(op_b)) : 64'(op_b);
        neg_d      = op_a[63] != op_b[63];
        sum_d      = (phase_q == hpp_pkg::PH_PROD) ? HALF_PROD : HALF_HORNER;
        part_num_d = (phase_q == hpp_pkg::PH_PROD) ? hpp_pkg::PROD_PARTS
                                                   : hpp_pkg::HORNER_PARTS;
        part_cnt_d = 3'd0;
        state_d    = hpp_pkg::ST_MUL;
      end

      hpp_pkg::ST_MUL: begin
        // The product of one cycle is added in the next one.
        if (part_cnt_q != 3'd0) begin
          sum_d = sum_q + ({64'd0, pp_q} << (7'd32 * 7'(pp_shift_q)));
        end
        if (part_cnt_q != part_num_q) begin
          pp_d       = mul_p;
          pp_shift_d = 2'(part_cnt_q[0]) + 2'(part_cnt_q[1]);
          part_cnt_d = part_cnt_q + 3'd1;
        end else begin
          state_d = hpp_pkg::ST_FIN;
        end
      end

      hpp_pkg::ST_FIN: begin
        state_d = hpp_pkg::ST_SETUP;
        acc_d   = fin_val;
        case (phase_q)
          hpp_pkg::PH_P1: begin
            if (coef_idx_q == hpp_pkg::P1_LAST_IDX) begin
              p1_d       = fin_val;
              acc_d      = 64'sd0;
              phase_d    = hpp_pkg::PH_P2;
              coef_idx_d = hpp_pkg::P2_FIRST_IDX;
            end else begin
              coef_idx_d = coef_idx_q - 5'd1;
            end
          end
          hpp_pkg::PH_P2: begin
            if (coef_idx_q == hpp_pkg::P2_LAST_IDX) begin
              p2_d    = p2_sat;
              phase_d = hpp_pkg::PH_PROD;
            end else begin
              coef_idx_d = coef_idx_q - 5'd1;
            end
          end
          default: begin
            prod_d  = fin_val[hpp_pkg::PROD_WIDTH-1:0];
            state_d = hpp_pkg::ST_RESULT;
          end
        endcase
      end

      hpp_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_err_d   = err_q;
          out_p1_d    = err_q ? '0 : p1_q;
          out_p2_d    = err_q ? '0 : p2_q;
          out_prod_d  = err_q ? '0 : prod_q;
          state_d     = hpp_pkg::ST_IDLE;
        end
      end

      default: state_d = hpp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hpp_pkg::ST_IDLE;
      phase_q     <= hpp_pkg::PH_P1;
      coef_idx_q  <= '0;
      part_cnt_q  <= '0;
      part_num_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      coef_idx_q  <= coef_idx_d;
      part_cnt_q  <= part_cnt_d;
      part_num_q  <= part_num_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    err_q      <= err_d;
    acc_q      <= acc_d;
    p1_q       <= p1_d;
    p2_q       <= p2_d;
    prod_q     <= prod_d;
    a_mag_q    <= a_mag_d;
    b_mag_q    <= b_mag_d;
    neg_q      <= neg_d;
    sum_q      <= sum_d;
    pp_q       <= pp_d;
    pp_shift_q <= pp_shift_d;
    out_err_q  <= out_err_d;
    out_p1_q   <= out_p1_d;
    out_p2_q   <= out_p2_d;
    out_prod_q <= out_prod_d;
  end

endmodule

`default_nettype wire

/* design/hpp_checker.sv */
// ----------------------------------------------------------------------------
// hpp_checker: port-level assertions for the Horner core
// Watches the argument and result channels and is bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module hpp_checker (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  in_valid_i,
  input wire                                  in_ready_i,
  input wire                                  out_valid_i,
  input wire                                  out_ready_i,
  input wire                                  range_error_i,
  input wire [hpp_pkg::P1_WIDTH-1:0]          first_poly_i,
  input wire [hpp_pkg::P2_WIDTH-1:0]          second_poly_i,
  input wire [hpp_pkg::PROD_WIDTH-1:0]        poly_product_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(first_poly_i) && $stable(second_poly_i)
      && $stable(poly_product_i) && $stable(range_error_i))
    else $error("result changed while stalled");

  // The core is not ready again in the cycle after taking an argument.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("argument accepted in back-to-back cycles");

  // A range error carries zero values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && range_error_i |-> first_poly_i == '0 && second_poly_i == '0
      && poly_product_i == '0)
    else $error("range error with nonzero values");

  // A new result only appears after the core was busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("result appeared while idle");

endmodule

bind horner_two_poly_product_core hpp_checker u_hpp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .range_error_i  (out_o.range_error),
  .first_poly_i   (out_o.first_poly),
  .second_poly_i  (out_o.second_poly),
  .poly_product_i (out_o.poly_product)
);

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for horner_two_poly_product_core
// Sends fixed-point arguments over the valid/ready input channel and checks
// every result transaction against a bit-exact fixed-point evaluation of both
// polynomials and their product. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb;

  localparam int unsigned FRAC       = 28;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned DRAIN_WAIT = 110;
  localparam int unsigned RAND_ARGS  = 1280;
  localparam int unsigned QUIET_TAIL = 150;
  localparam int unsigned LONG_HOLD  = 600;
  localparam int unsigned COEF_COUNT = 18;

  // Largest in-range argument code, 5.0 in Q.28.
  localparam int unsigned X_BOUND_CODE = hpp_pkg::X_LIMIT_INT << FRAC;

  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PROD_MAX  = (64'd1 << (hpp_pkg::PROD_WIDTH - 1)) - 64'd1;
  localparam longint      P2_MAX    = (64'sd1 << (hpp_pkg::P2_WIDTH - 1)) - 64'sd1;

  typedef struct {
    logic signed [hpp_pkg::X_WIDTH-1:0]    arg;
    logic                                  range_error;
    logic signed [hpp_pkg::P1_WIDTH-1:0]   first_poly;
    logic signed [hpp_pkg::P2_WIDTH-1:0]   second_poly;
    logic signed [hpp_pkg::PROD_WIDTH-1:0] poly_product;
  } poly_result_t;

  typedef struct {
    logic signed [hpp_pkg::X_WIDTH-1:0] x;
    bit                                 wait_drain;
  } arg_item_t;

  logic clk_i;
  logic rst_n;

  hpp_in_if  in_if ();
  hpp_out_if out_if ();

  horner_two_poly_product_core #(
    .FRAC_BITS(FRAC)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  arg_item_t    pending_args [$];
  poly_result_t expected_polys [$];
  longint       coef_table [COEF_COUNT];

  int unsigned arg_total;
  int unsigned args_taken;
  int unsigned results_seen;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned idle_pct;
  int unsigned src_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  bit          long_hold_done;
  bit          arg_accepted;

  // --------------------------------------------------------------------------
  // Fixed-point arithmetic of the evaluator
  // --------------------------------------------------------------------------

  // Coefficient num/den rounded to nearest with FRAC fraction bits.
  function automatic longint q_coef(longint num, longint den);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (num < 0) ? -num : num;
    q   = ((mag << FRAC) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // round(a*b / 2^sh), ties away from zero, saturated to [-maxpos-1, maxpos].
  function automatic longint round_mul(longint a, longint b, int unsigned sh,
                                       logic [63:0] maxpos);
    logic         neg;
    logic [63:0]  ma;
    logic [63:0]  mb;
    logic [63:0]  lim;
    logic [63:0]  q;
    logic [127:0] wide;
    neg  = (a < 0) != (b < 0);
    ma   = a;
    mb   = b;
    if (a < 0) ma = -ma;
    if (b < 0) mb = -mb;
    wide = {64'd0, ma} * {64'd0, mb};
    wide = (wide + (128'd1 << (sh - 1))) >> sh;
    lim  = neg ? maxpos + 64'd1 : maxpos;
    q    = (wide > {64'd0, lim}) ? lim : wide[63:0];
    return neg ? longint'(-q) : longint'(q);
  endfunction

  function automatic longint sat_add64(longint a, longint b);
    logic signed [64:0] s;
    s = a;
    s = s + b;
    if (!s[64] && s[63]) return longint'(INT64_MAX);
    if (s[64] && !s[63]) return longint'(~INT64_MAX);
    return s[63:0];
  endfunction

  // Horner's rule over coefficient entries first down to last.
  function automatic longint horner_eval(longint xs, logic [4:0] first,
                                         logic [4:0] last);
    longint acc;
    acc = 0;
    for (int i = first; i >= int'(last); i--) begin
      acc = sat_add64(round_mul(acc, xs, FRAC, INT64_MAX), coef_table[i]);
    end
    return acc;
  endfunction

  function automatic poly_result_t eval_polys(logic signed [hpp_pkg::X_WIDTH-1:0] x);
    poly_result_t r;
    longint       xs;
    longint       lim;
    longint       p1;
    longint       p2;
    longint       prod;
    xs             = x;
    lim            = longint'(hpp_pkg::X_LIMIT_INT) << FRAC;
    r.arg          = x;
    r.range_error  = 1'b0;
    r.first_poly   = '0;
    r.second_poly  = '0;
    r.poly_product = '0;
    if (xs < -lim || xs > lim) begin
      r.range_error = 1'b1;
      return r;
    end
    p1 = horner_eval(xs, hpp_pkg::P1_FIRST_IDX, hpp_pkg::P1_LAST_IDX);
    p2 = horner_eval(xs, hpp_pkg::P2_FIRST_IDX, hpp_pkg::P2_LAST_IDX);
    if (p2 > P2_MAX) p2 = P2_MAX;
    if (p2 < -P2_MAX - 1) p2 = -P2_MAX - 1;
    prod = round_mul(p1, p2, 2 * FRAC - hpp_pkg::PROD_FRAC, PROD_MAX);
    r.first_poly   = p1;
    r.second_poly  = p2[hpp_pkg::P2_WIDTH-1:0];
    r.poly_product = prod[hpp_pkg::PROD_WIDTH-1:0];
    return r;
  endfunction

  task automatic queue_arg(input logic signed [hpp_pkg::X_WIDTH-1:0] x,
                           input bit drain);
    arg_item_t item;
    item.x          = x;
    item.wait_drain = drain;
    pending_args.push_back(item);
  endtask

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Argument driver: changes the input channel only at the falling edge.
  // A new argument is offered once the previous one was taken, unless a
  // random idle burst is running or the next argument is marked to wait for
  // the result queue to empty.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_n) begin
      if (!in_if.valid || arg_accepted) begin
        if (arg_accepted && $urandom_range(0, 99) < idle_pct) begin
          src_gap = $urandom_range(1, 12);
        end
        if (src_gap > 0) begin
          src_gap = src_gap - 1;
          in_if.valid <= 1'b0;
        end else if (pending_args.size() > 0 &&
                     !(pending_args[0].wait_drain && expected_polys.size() > 0)) begin
          in_if.valid   <= 1'b1;
          in_if.x_value <= pending_args[0].x;
          void'(pending_args.pop_front());
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: drives ready at the falling edge. Once, after a couple
  // of hundred results, ready stays low for a long stretch so the core backs
  // up and stalls its input while the driver keeps offering arguments.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_n) begin
      if (!long_hold_done && results_seen >= 200) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_if.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap = sink_gap - 1;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct / 3) begin
        sink_gap = $urandom_range(1, 12) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and predictor: both channels are sampled at the rising edge.
  // The result side is checked first; a result never leaves in the same
  // cycle as the argument that caused it.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    poly_result_t want;
    arg_accepted = 1'b0;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        results_seen = results_seen + 1;
        if (expected_polys.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result transaction: err=%b p1=%h p2=%h prod=%h",
                     out_if.range_error, out_if.first_poly, out_if.second_poly,
                     out_if.poly_product);
          end
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_polys.pop_front();
          if (out_if.range_error !== want.range_error ||
              out_if.first_poly !== want.first_poly ||
              out_if.second_poly !== want.second_poly ||
              out_if.poly_product !== want.poly_product) begin
            if (mismatch_count < 10) begin
              $display("mismatch for x=%h", want.arg);
              $display("  expected: err=%b p1=%h p2=%h prod=%h", want.range_error,
                       want.first_poly, want.second_poly, want.poly_product);
              $display("  actual:   err=%b p1=%h p2=%h prod=%h", out_if.range_error,
                       out_if.first_poly, out_if.second_poly, out_if.poly_product);
            end
            mismatch_count = mismatch_count + 1;
          end
        end
      end

      if (in_if.valid && in_if.ready) begin
        arg_accepted = 1'b1;
        expected_polys.push_back(eval_polys(in_if.x_value));
        args_taken = args_taken + 1;
        // Idle density changes every hundred arguments; the tail runs flat out.
        if (arg_total - args_taken <= QUIET_TAIL) begin
          idle_pct = 0;
        end else begin
          case ((args_taken / 100) % 4)
            0: idle_pct = 20;
            1: idle_pct = 0;
            2: idle_pct = 50;
            default: idle_pct = 8;
          endcase
        end
      end
    end
  end

  // Hard stop in case the core hangs.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic [63:0]                        raw;
    logic signed [hpp_pkg::X_WIDTH-1:0] xv;
    int unsigned                        pick;
    longint                             base;

    in_if.valid    = 1'b0;
    in_if.x_value  = '0;
    out_if.ready   = 1'b0;
    rst_n          = 1'b0;
    args_taken     = 0;
    results_seen   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    idle_pct       = 20;
    src_gap        = 0;
    sink_gap       = 0;
    hold_left      = 0;
    long_hold_done = 1'b0;
    arg_accepted   = 1'b0;

    // p1 uses x^6, x^8 and x^10; p2 = x^6 - x^5 + 2x^4 - x^3.
    for (int i = 0; i < COEF_COUNT; i++) coef_table[i] = 0;
    coef_table[6]  = q_coef(6243, 10);
    coef_table[8]  = q_coef(-5253243, 100);
    coef_table[10] = q_coef(-12107, 5000);
    coef_table[14] = q_coef(-1, 1);
    coef_table[15] = q_coef(2, 1);
    coef_table[16] = q_coef(-1, 1);
    coef_table[17] = q_coef(1, 1);

    // Directed: zero, tiny values, whole numbers, both range edges exactly,
    // one LSB inside and outside each edge, the extreme codes and alternating bits.
    base = longint'(X_BOUND_CODE);
    queue_arg('0, 1'b0);
    queue_arg(36'sd1, 1'b0);
    queue_arg(-36'sd1, 1'b0);
    queue_arg(36'sd1 << FRAC, 1'b0);
    queue_arg(-(36'sd1 << FRAC), 1'b0);
    queue_arg(36'sd2 << FRAC, 1'b0);
    queue_arg(-(36'sd3 << FRAC), 1'b0);
    queue_arg(36'sd1 << (FRAC - 1), 1'b0);
    queue_arg(base, 1'b0);
    queue_arg(-base, 1'b0);
    queue_arg(base - 1, 1'b0);
    queue_arg(-base + 1, 1'b0);
    queue_arg(base + 1, 1'b0);
    queue_arg(-base - 1, 1'b0);
    queue_arg({1'b0, {(hpp_pkg::X_WIDTH-1){1'b1}}}, 1'b0);
    queue_arg({1'b1, {(hpp_pkg::X_WIDTH-1){1'b0}}}, 1'b0);
    queue_arg(36'h5_5555_5555, 1'b0);
    queue_arg(36'hA_AAAA_AAAA, 1'b0);
    queue_arg(36'sd993046937, 1'b0);
    queue_arg(-36'sd1339493417, 1'b0);

    // Random: mostly in-range arguments, with small magnitudes, values at the
    // range edges and arbitrary 36-bit codes mixed in. Two arguments wait
    // until every pending result has come back.
    for (int n = 0; n < RAND_ARGS; n++) begin
      pick = $urandom_range(0, 99);
      raw  = {$urandom, $urandom};
      if (pick < 60) begin
        xv = longint'($urandom_range(0, 2 * X_BOUND_CODE)) - base;
      end else if (pick < 70) begin
        xv = longint'($urandom_range(0, 1 << 21)) - (64'sd1 << 20);
      end else if (pick < 80) begin
        xv = base + longint'($urandom_range(0, 16)) - 8;
        if (raw[40]) xv = -xv;
      end else begin
        xv = raw[hpp_pkg::X_WIDTH-1:0];
      end
      queue_arg(xv, n == 500 || n == 1000);
    end
    arg_total = pending_args.size();

    repeat (6) @(negedge clk_i);
    rst_n <= 1'b1;

    while (pending_args.size() > 0 || in_if.valid) @(posedge clk_i);
    while (expected_polys.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
design/hpp_pkg.sv
design/hpp_in_if.sv
design/hpp_out_if.sv
design/horner_two_poly_product_core.sv
design/hpp_checker.sv
sim/tb.sv
